// ----- design/rpsm_pkg.sv -----
`timescale 1ns / 1ps
// rpsm_pkg: shared types, constants and pattern text for the RTSP signature matcher.
// No dependencies; used by rpsm_cell and rtsp_payload_signature_match_core.

package rpsm_pkg;

	localparam int NUM_PAT   = 12;     // version string plus eleven methods
	localparam int PAT_MAX   = 21;     // longest pattern: a PARAMETER method, space, prefix
	localparam int PAT_W     = PAT_MAX * 8;
	localparam int PAT_IDX_W = $clog2(PAT_MAX);
	localparam int PAT_SEL_W = $clog2(NUM_PAT);
	localparam int POS_W     = 8;
	localparam int LEN_W     = 8;

	localparam logic [POS_W-1:0] POS_SAT     = '1;
	localparam logic [LEN_W-1:0] MIN_LEN_RST = 8'd15;

	// Per-word broadcast from the top level down the row of cells.
	typedef struct packed {
		logic             step;   // word accepted this cycle
		logic             last;   // word closes the payload
		logic [POS_W-1:0] pos;    // byte offset of this word
		logic [7:0]       data;   // payload byte
	} cell_in_t;

	// Pattern length in bytes (method, space and scheme prefix included).
	function automatic logic [PAT_IDX_W-1:0] pat_len(input logic [PAT_SEL_W-1:0] k);
		logic [PAT_IDX_W-1:0] n;
		unique case (k)
			4'd0:    n = 5'd8;
			4'd1:    n = 5'd16;
			4'd2:    n = 5'd15;
			4'd3:    n = 5'd12;
			4'd4:    n = 5'd13;
			4'd5:    n = 5'd14;
			4'd6:    n = 5'd16;
			4'd7:    n = 5'd13;
			4'd8:    n = 5'd16;
			4'd9:    n = 5'd21;
			4'd10:   n = 5'd21;
			4'd11:   n = 5'd16;
			default: n = '0;
		endcase
		return n;
	endfunction

	// Pattern text, right aligned: byte p sits at bits [(len-1-p)*8 +: 8].
	// lc selects the lower case scheme prefix; method text never changes case.
	function automatic logic [PAT_W-1:0] pat_text(input logic [PAT_SEL_W-1:0] k,
		input logic lc);
		logic [PAT_W-1:0] r;
		r = '0;
		unique case (k)
			4'd0:    r = "RTSP/1.0";
			4'd1:    r = lc ? "DESCRIBE rtsp://"      : "DESCRIBE RTSP://";
			4'd2:    r = lc ? "OPTIONS rtsp://"       : "OPTIONS RTSP://";
			4'd3:    r = lc ? "PLAY rtsp://"          : "PLAY RTSP://";
			4'd4:    r = lc ? "PAUSE rtsp://"         : "PAUSE RTSP://";
			4'd5:    r = lc ? "RECORD rtsp://"        : "RECORD RTSP://";
			4'd6:    r = lc ? "REDIRECT rtsp://"      : "REDIRECT RTSP://";
			4'd7:    r = lc ? "SETUP rtsp://"         : "SETUP RTSP://";
			4'd8:    r = lc ? "ANNOUNCE rtsp://"      : "ANNOUNCE RTSP://";
			4'd9:    r = lc ? {"GET_", "PARAMETER rtsp://"} : {"GET_", "PARAMETER RTSP://"};
			4'd10:   r = lc ? {"SET_", "PARAMETER rtsp://"} : {"SET_", "PARAMETER RTSP://"};
			4'd11:   r = lc ? "TEARDOWN rtsp://"      : "TEARDOWN RTSP://";
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- design/rpsm_cell.sv -----
`timescale 1ns / 1ps
// rpsm_cell: one pattern matcher of the row; keeps the pattern's alive bit.
// Depends on rpsm_pkg.

module rpsm_cell #(
	parameter int K = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rpsm_pkg::cell_in_t cin,
	input  logic               found_in,
	output logic               found_out
);

	localparam logic [rpsm_pkg::PAT_SEL_W-1:0] KSEL = rpsm_pkg::PAT_SEL_W'(K);
	localparam logic [rpsm_pkg::PAT_IDX_W-1:0] TOTAL = rpsm_pkg::pat_len(KSEL);
	localparam logic [rpsm_pkg::PAT_W-1:0] UP = rpsm_pkg::pat_text(KSEL, 1'b0);
	localparam logic [rpsm_pkg::PAT_W-1:0] LO = rpsm_pkg::pat_text(KSEL, 1'b1);
	localparam logic [rpsm_pkg::POS_W-1:0] TOT_POS  = rpsm_pkg::POS_W'(TOTAL);
	localparam logic [rpsm_pkg::POS_W-1:0] LAST_POS = TOT_POS - 1'b1;

	logic                          alive_q;
	logic [rpsm_pkg::PAT_MAX-1:0]  chr_hit;
	logic [rpsm_pkg::PAT_IDX_W-1:0] idx;
	logic                          match;
	logic                          done;

	// Compare the byte against every character of the pattern at once.
	always_comb begin
		chr_hit = '0;
		for (int j = 0; j < rpsm_pkg::PAT_MAX; j++) begin
			if (j < int'(TOTAL)) begin
				chr_hit[j] = (cin.data == UP[(int'(TOTAL) - 1 - j) * 8 +: 8]) ||
					(cin.data == LO[(int'(TOTAL) - 1 - j) * 8 +: 8]);
			end
		end
	end

	assign idx   = cin.pos[rpsm_pkg::PAT_IDX_W-1:0];
	assign match = (cin.pos < TOT_POS) ? chr_hit[idx] : 1'b0;
	assign done  = alive_q && match && (cin.pos == LAST_POS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= 1'b1;
		end else if (cin.step) begin
			if (cin.last) begin
				alive_q <= 1'b1;
			end else if (!match || done) begin
				alive_q <= 1'b0;
			end
		end
	end

	// Found flag ripples along the row.
	assign found_out = found_in || (cin.step && done);

endmodule

// ----- design/rtsp_payload_signature_match_core.sv -----
`timescale 1ns / 1ps
// rtsp_payload_signature_match_core: top level of the RTSP payload signature matcher.
// Depends on rpsm_pkg and rpsm_cell.

// Takes one payload byte per cycle on the input channel (data_byte, last_byte)
// and gives one verdict word per packet on the output channel, in the cycle after
// the packet's last byte is taken. is_rtsp is 1 when the payload begins with
// "RTSP/1.0", or with one of DESCRIBE, OPTIONS, PLAY, PAUSE, RECORD, REDIRECT,
// SETUP, ANNOUNCE, TEARDOWN or either PARAMETER method (GET and SET) followed
// by a space and "rtsp://" (each prefix letter in either case), the whole
// pattern lying inside the payload, and the payload is at least
// min_payload_len bytes long.
// Throughput is one byte per cycle: twelve matcher cells each compare the byte
// against their own pattern in parallel and hand a found flag down the row.
// in_ready falls only while a verdict sits in the output register and
// out_ready is low. cfg_we writes min_payload_len (reset 15) at once; write it
// only between packets.

module rtsp_payload_signature_match_core (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	// byte input
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	// verdict output
	output logic       out_valid,
	input  logic       out_ready,
	output logic       is_rtsp
);

	logic [rpsm_pkg::LEN_W-1:0] min_len_q;
	logic [rpsm_pkg::POS_W-1:0] pos_q;
	logic [rpsm_pkg::POS_W-1:0] pos_inc;
	logic                       found_q;
	logic                       out_valid_q;
	logic                       is_rtsp_q;
	logic                       step;
	rpsm_pkg::cell_in_t         cin;
	logic [rpsm_pkg::NUM_PAT:0] chain;   // found flag between neighbors
	logic                       verdict;

	// Output slot frees when empty or being read; the row itself never stalls.
	assign in_ready = !out_valid_q || out_ready;
	assign step     = in_valid && in_ready;

	assign cin.step = step;
	assign cin.last = last_byte;
	assign cin.pos  = pos_q;
	assign cin.data = data_byte;

	assign chain[0] = 1'b0;

	for (genvar k = 0; k < rpsm_pkg::NUM_PAT; k++) begin : g_cell
		rpsm_cell #(.K(k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cin      (cin),
			.found_in (chain[k]),
			.found_out(chain[k+1])
		);
	end

	// Byte count saturates; the count after this word is the payload length.
	assign pos_inc = (pos_q == rpsm_pkg::POS_SAT) ? pos_q : pos_q + 1'b1;
	assign verdict = (found_q || chain[rpsm_pkg::NUM_PAT]) && (pos_inc >= min_len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= rpsm_pkg::MIN_LEN_RST;
		end else if (cfg_we) begin
			min_len_q <= cfg_wdata;
		end
	end

	// Per-packet state, cleared after the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			found_q <= 1'b0;
		end else if (step) begin
			if (last_byte) begin
				pos_q   <= '0;
				found_q <= 1'b0;
			end else begin
				pos_q   <= pos_inc;
				found_q <= found_q || chain[rpsm_pkg::NUM_PAT];
			end
		end
	end

	// Verdict register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_byte) begin
			is_rtsp_q <= verdict;
		end
	end

	assign out_valid = out_valid_q;
	assign is_rtsp   = is_rtsp_q;

endmodule

// ----- design/rpsm_checker.sv -----
`timescale 1ns / 1ps
// rpsm_checker: port-level assertions for rtsp_payload_signature_match_core.
// Bound to the top level below; no package dependency.

module rpsm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       last_byte,
	input logic       out_valid,
	input logic       out_ready,
	input logic       is_rtsp
);

	// A held verdict stays put until read.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(is_rtsp))
		else $error("verdict dropped or changed while stalled");

	// A last byte always yields a verdict word next cycle.
	a_last_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_byte |=> out_valid)
		else $error("no verdict after last byte");

	// A middle byte never invents a verdict.
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !last_byte && (!out_valid || out_ready) |=> !out_valid)
		else $error("verdict without last byte");

	// Input must stall rather than overwrite an unread verdict.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken over unread verdict");

endmodule

bind rtsp_payload_signature_match_core rpsm_checker u_rpsm_checker (.*);

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking testbench for rtsp_payload_signature_match_core.
// Depends on the core RTL and rpsm_pkg; needs no files or plusargs.

// How it works
//  - Packets are built as byte queues: well-formed signatures with random
//    prefix case and random tails, truncated and corrupted signatures, plain
//    noise, and a few very long payloads that saturate the byte counter.
//  - rtsp_verdict_tracker predicts the verdict for every accepted last word
//    and compares it against each verdict word taken from the output.
//  - The run walks through several min_payload_len settings (reset value,
//    0, 255 and values around the signature lengths). A setting is written
//    only after every pending verdict has drained.
//  - The sender idles in bursts and gaps; the receiver stalls in its own
//    pattern, plus one long hold so the output backs up into the input.

module tb_top;

	// Pattern text and predictor state for the RTSP signature check.
	class rtsp_verdict_tracker;
		bit         expected_verdicts[$];
		logic [7:0] min_len;
		logic [7:0] byte_pos;
		logic [11:0] sig_alive;
		bit         sig_hit;
		int         errors;
		int         packets;
		int         rtsp_seen;

		function new();
			min_len = 8'd15;
			errors = 0;
			packets = 0;
			rtsp_seen = 0;
			clear_packet();
		endfunction

		// request method for signature k = 1..11; k = 0 is the version string
		static function string verb(int k);
			case (k)
				1:       return "DESCRIBE";
				2:       return "OPTIONS";
				3:       return "PLAY";
				4:       return "PAUSE";
				5:       return "RECORD";
				6:       return "REDIRECT";
				7:       return "SETUP";
				8:       return "ANNOUNCE";
				9:       return $sformatf("%s_PARAMETER", "GET");
				10:      return $sformatf("%s_PARAMETER", "SET");
				11:      return "TEARDOWN";
				default: return "";
			endcase
		endfunction

		static function int sig_len(int k);
			if (k == 0)
				return 8;
			return verb(k).len() + 8;
		endfunction

		// byte p of signature k; lower picks the lower case scheme prefix
		static function logic [7:0] sig_char(int k, int p, bit lower);
			string s;
			int    ml;
			if (k == 0) begin
				s = "RTSP/1.0";
				return s[p];
			end
			s = verb(k);
			ml = s.len();
			if (p < ml)
				return s[p];
			if (p == ml)
				return 8'h20;
			s = lower ? "rtsp://" : "RTSP://";
			return s[p - ml - 1];
		endfunction

		function void clear_packet();
			byte_pos = '0;
			sig_alive = '1;
			sig_hit = 1'b0;
		endfunction

		function void set_min_len(logic [7:0] v);
			min_len = v;
		endfunction

		function int pending();
			return expected_verdicts.size();
		endfunction

		// accepted input word: advance every live signature by one byte
		function void note_byte(logic [7:0] b, logic fin);
			int k;
			int total;
			for (k = 0; k < 12; k++) begin
				if (!sig_alive[k])
					continue;
				total = sig_len(k);
				if (byte_pos >= total ||
					(b != sig_char(k, byte_pos, 1'b0) && b != sig_char(k, byte_pos, 1'b1))) begin
					sig_alive[k] = 1'b0;
				end else if (byte_pos == total - 1) begin
					sig_hit = 1'b1;
					sig_alive[k] = 1'b0;
				end
			end
			if (byte_pos != 8'hFF)
				byte_pos++;
			if (fin) begin
				expected_verdicts.push_back(sig_hit && byte_pos >= min_len);
				clear_packet();
			end
		endfunction

		function void check_verdict(logic got);
			bit want;
			if (expected_verdicts.size() == 0) begin
				$error("verdict word with nothing expected: is_rtsp=%0b", got);
				errors++;
				return;
			end
			want = expected_verdicts.pop_front();
			packets++;
			if (got === 1'b1)
				rtsp_seen++;
			if (got !== want) begin
				$error("is_rtsp mismatch: expected %0d, actual %0b", want, got);
				errors++;
			end
		endfunction
	endclass

	typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_CHOKED} rx_style_e;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_BYTES  = 100;
	localparam int NUM_PHASES   = 11;
	localparam int LONG_HOLD    = 400;
	localparam int SETTLE       = 4;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] data_byte = '0;
	logic       last_byte = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       is_rtsp;

	rtsp_verdict_tracker tracker = new();

	logic [7:0] pkt[$];
	int         burst_left = 0;
	bit         tx_steady = 1'b0;
	int         bytes_sent = 0;
	int         long_count = 0;
	int         cfg_writes = 0;
	int         cycle_count = 0;

	rx_style_e  rx_mode = RX_OPEN;
	int         rx_tick = 0;
	int         rx_hold_req = 0;
	int         rx_hold_left = 0;

	rtsp_payload_signature_match_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.is_rtsp   (is_rtsp)
	);

	always #4 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// both handshakes are sampled here, on pre-edge values
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				tracker.note_byte(data_byte, last_byte);
			if (out_valid && out_ready)
				tracker.check_verdict(is_rtsp);
		end
	end

	// receiver: style is redrawn at random as rx_tick runs; a requested hold overrides it
	always @(posedge clk) begin
		rx_tick++;
		if (rx_tick % 64 == 0)
			rx_mode = rx_style_e'($urandom_range(0, 3));
		if (rx_hold_req != 0) begin
			rx_hold_left = rx_hold_req;
			rx_hold_req = 0;
		end
		if (rx_hold_left != 0) begin
			rx_hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_OPEN:    out_ready <= 1'b1;
				RX_RANDOM:  out_ready <= ($urandom_range(0, 3) != 0);
				RX_PATTERN: out_ready <= ((rx_tick % 5) < 2);
				default:    out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// one word; valid stays up after acceptance until the next call or a gap
	task automatic send_word(input logic [7:0] b, input logic fin);
		int gap;
		if (burst_left == 0) begin
			gap = tx_steady ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= fin;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_packet();
		int i;
		for (i = 0; i < pkt.size(); i++)
			send_word(pkt[i], i == pkt.size() - 1);
		bytes_sent += pkt.size();
	endtask

	// stop offering and wait for every verdict, then let the pipe settle;
	// the first edge lets the last accepted word reach the tracker
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (tracker.pending() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_min_len(input logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_min_len(v);
		cfg_writes++;
	endtask

	// full signature k, each scheme letter in random case
	task automatic build_signature(input int k);
		int p;
		pkt.delete();
		for (p = 0; p < rtsp_verdict_tracker::sig_len(k); p++)
			pkt.push_back(rtsp_verdict_tracker::sig_char(k, p, $urandom_range(0, 1)));
	endtask

	task automatic add_tail(input int n);
		repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic random_packet();
		int r;
		int k;
		int n;
		r = $urandom_range(0, 99);
		k = $urandom_range(0, 11);
		if (r < 55) begin
			build_signature(k);
			add_tail($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 20));
		end else if (r < 65) begin
			// signature cut short by the end of the payload
			build_signature(k);
			n = $urandom_range(1, pkt.size() - 1);
			while (pkt.size() > n)
				void'(pkt.pop_back());
		end else if (r < 80) begin
			// one byte off: case flip (harmless on scheme letters) or random
			build_signature(k);
			n = $urandom_range(0, pkt.size() - 1);
			if ($urandom_range(0, 1))
				pkt[n] = pkt[n] ^ 8'h20;
			else
				pkt[n] = 8'($urandom_range(0, 255));
			add_tail($urandom_range(0, 12));
		end else if (r < 98 || long_count >= 4) begin
			pkt.delete();
			if ($urandom_range(0, 1)) begin
				build_signature(k);
				n = $urandom_range(1, 5);
				while (pkt.size() > n)
					void'(pkt.pop_back());
			end
			add_tail($urandom_range(1, 30));
		end else begin
			build_signature(k);
			add_tail($urandom_range(240, 300));
			long_count++;
		end
	endtask

	initial begin
		int phase;
		int phase_bytes;
		logic [7:0] setting;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: byte extremes as one-word packets, version string at the
		// reset minimum length, and a version string one byte short
		pkt = '{8'hFF};
		send_packet();
		pkt = '{8'h00};
		send_packet();
		build_signature(0);
		pkt.push_back(8'h00);
		add_tail(5);
		pkt.push_back(8'hFF);
		send_packet();
		build_signature(0);
		void'(pkt.pop_back());
		send_packet();
		drain();

		for (phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0:       setting = 8'd15;
				1:       setting = 8'd0;
				2:       setting = 8'd255;
				3:       setting = 8'd1;
				4:       setting = 8'd8;
				5:       setting = 8'd16;
				6:       setting = 8'd21;
				7:       setting = 8'd22;
				10:      setting = 8'd13;
				default: setting = 8'($urandom_range(0, 40));
			endcase
			if (phase != 0)
				write_min_len(setting);
			tx_steady = (phase % 3 == 2);

			if (setting == 8'd255) begin
				// only a saturated payload can pass at this minimum
				build_signature($urandom_range(0, 11));
				add_tail(260 - pkt.size());
				send_packet();
			end
			if (phase == 3)
				rx_hold_req = LONG_HOLD;	// output backs up into the input

			phase_bytes = bytes_sent;
			while (bytes_sent - phase_bytes < PHASE_BYTES) begin
				random_packet();
				send_packet();
			end
			drain();
		end

		$display("%0d payload bytes in, %0d verdicts checked (%0d rtsp)",
			bytes_sent, tracker.packets, tracker.rtsp_seen);
		$display("%0d min_payload_len writes, %0d saturating payloads",
			cfg_writes, long_count);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
